// ===== rtl/core/ses_pkg.sv =====
// ----------------------------------------------------------------------------
// ses_pkg
// Shared types and constants of the selection exchange sorter.
// ----------------------------------------------------------------------------
package ses_pkg;

   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      value_type value;
      logic      last;
   } req_type;

   typedef struct packed {
      value_type sorted_value;
      logic      final_res;
      logic      overflow;
   } rsp_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/ses_cell.sv =====
// ----------------------------------------------------------------------------
// ses_cell
// One slot of the insertion chain: holds a value, takes its left neighbor's
// value or the new item on insertion, takes its right neighbor's on drain.
// ----------------------------------------------------------------------------
module ses_cell
   import ses_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  value_type     new_value,
   input  value_type     prev_value,
   input  logic          prev_valid,
   input  logic          prev_lt,
   input  value_type     next_value,
   input  logic          next_valid,
   output value_type     value,
   output logic          valid,
   output logic          lt
);

   value_type value_ff, value_in;
   logic      valid_ff, valid_in;

   // empty slot counts as +infinity; equal values insert behind
   assign lt = !valid_ff || ($signed(new_value) < $signed(value_ff));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (ctrl.insert && lt) begin
         value_in = prev_lt ? prev_value : new_value;
         valid_in = valid_ff | prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

// ===== rtl/core/selection_exchange_sorter_top.sv =====
// ----------------------------------------------------------------------------
// selection_exchange_sorter_top
// Collects a set of signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
// Input items (req_) carry one signed 32-bit value each; last closes the set.
// Each item is inserted into a row of MAX_ELEMENTS cells on acceptance, so a
// set streams in at one item per cycle. Items beyond MAX_ELEMENTS are
// dropped and overflow is set on every result of that set.
// After the last item the row drains from its low end: one result per cycle
// on rsp_, smallest first, final_res on the greatest. A set of n kept values
// is returned as n results; once the last item is accepted the state register
// turns to drain, and the first result is then loaded into the output register.
// req_ready is low while the row drains, and stays low through any rsp_ stalls.
// The output register lets the next set start filling while the final
// result still waits on rsp_ready. A stall on rsp_ simply pauses the drain.
// Reset empties the row and clears the count and overflow flag.
// ----------------------------------------------------------------------------
module selection_exchange_sorter_top
   import ses_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            dropped_ff, dropped_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            req_fire, full, drain_step;
   cell_ctrl_type   ctrl;

   value_type              cell_value [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] cell_valid;
   logic [MAX_ELEMENTS-1:0] cell_lt;

   assign req_ready  = (state_ff == ST_FILL);
   assign req_fire   = req_valid && req_ready;
   assign full       = (count_ff == CNT_W'(MAX_ELEMENTS));
   assign drain_step = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready);
   assign ctrl.insert = req_fire && !full;
   assign ctrl.shift  = drain_step;

   genvar i;
   generate
      for (i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
         value_type prev_value, next_value;
         logic      prev_valid, prev_lt, next_valid;
         if (i == 0) begin : g_first
            assign prev_value = req_data.value;
            assign prev_valid = 1'b1;
            assign prev_lt    = 1'b0;
         end else begin : g_mid
            assign prev_value = cell_value[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_lt    = cell_lt[i-1];
         end
         if (i == MAX_ELEMENTS - 1) begin : g_end
            assign next_value = cell_value[i];
            assign next_valid = 1'b0;
         end else begin : g_inner
            assign next_value = cell_value[i+1];
            assign next_valid = cell_valid[i+1];
         end
         ses_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .new_value  (req_data.value),
            .prev_value (prev_value),
            .prev_valid (prev_valid),
            .prev_lt    (prev_lt),
            .next_value (next_value),
            .next_valid (next_valid),
            .value      (cell_value[i]),
            .valid      (cell_valid[i]),
            .lt         (cell_lt[i])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_fire) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (req_data.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (drain_step) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sorted_value = cell_value[0];
               rsp_data_in.final_res    = (count_ff == CNT_W'(1));
               rsp_data_in.overflow     = dropped_ff;
               count_in                 = count_ff - 1'b1;
               if (count_ff == CNT_W'(1)) begin
                  state_in   = ST_FILL;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count beyond capacity");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("occupied cells disagree with element count");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (count_ff != '0))
      else $error("drain with empty row");

   a_row_sorted: assert property (@(posedge clock) disable iff (reset)
      (cell_valid[1] && cell_valid[0]) |-> ($signed(cell_value[0]) <= $signed(cell_value[1])))
      else $error("row head out of order");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the selection exchange sorter.
// ----------------------------------------------------------------------------
// Sets of signed values are streamed in over req_. A behavioral model keeps
// the open set, applies the capacity limit and, on the closing item, queues
// the ascending results with final and overflow marks. Each rsp_ item is
// compared field by field with the oldest queued result. The stimulus runs
// directed edge values, capacity and overflow sets, a long receiver hold-off
// and random sets under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top
   import ses_pkg::*;
();

   localparam int MAX_ELEMENTS   = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = MAX_ELEMENTS + 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // model of the open set
   value_type open_set[$];
   logic      open_dropped = 1'b0;
   rsp_type   pending_sorted[$];
   rsp_type   wanted_rsp;

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   logic receiver_hold = 1'b0;
   event hold_go;

   int errors        = 0;
   int items_sent    = 0;
   int sets_closed   = 0;
   int overflow_sets = 0;
   int results_seen  = 0;
   int idle_count    = 0;

   selection_exchange_sorter_top #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic void absorb_element(input value_type v, input logic is_last);
      value_type ordered[$];
      value_type key;
      int        n;
      int        j;
      rsp_type   r;
      if (open_set.size() < MAX_ELEMENTS) begin
         open_set.push_back(v);
      end else begin
         open_dropped = 1'b1;
      end
      if (is_last) begin
         ordered = open_set;
         n = ordered.size();
         for (int i = 1; i < n; i++) begin
            key = ordered[i];
            j = i;
            while (j > 0 && ordered[j-1] > key) begin
               ordered[j] = ordered[j-1];
               j--;
            end
            ordered[j] = key;
         end
         for (int k = 0; k < n; k++) begin
            r.sorted_value = ordered[k];
            r.final_res    = (k == n - 1);
            r.overflow     = open_dropped;
            pending_sorted.push_back(r);
         end
         sets_closed++;
         if (open_dropped) overflow_sets++;
         open_set.delete();
         open_dropped = 1'b0;
      end
   endfunction

   task automatic send_item(input value_type v, input logic is_last);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= {$urandom, 1'($urandom)};
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{value: v, last: is_last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      absorb_element(v, is_last);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      stop_sending();
      while (pending_sorted.size() != 0) @(posedge clock);
   endtask

   function automatic value_type pick_value();
      int mode;
      mode = $urandom_range(9);
      case (mode)
         0, 1, 2, 3, 4: return value_type'($urandom);
         5, 6:          return value_type'($urandom_range(15)) - 8;
         7: begin
            case ($urandom_range(3))
               0:       return 32'sh7fffffff;
               1:       return 32'sh80000000;
               2:       return 32'sh0;
               default: return -32'sd1;
            endcase
         end
         default:       return value_type'($urandom_range(2000)) - 1000;
      endcase
   endfunction

   task automatic send_random_set(input int len);
      for (int k = 0; k < len; k++) send_item(pick_value(), k == len - 1);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      // edge values with a duplicate minimum
      send_item(32'sh7fffffff, 1'b0);
      send_item(32'sh80000000, 1'b0);
      send_item(32'sh0, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd1, 1'b0);
      send_item(32'sh80000000, 1'b1);
      // one-item sets
      send_item(32'sd5, 1'b1);
      send_item(32'sh7fffffff, 1'b1);
      send_item(32'sh80000000, 1'b1);
      // all equal
      for (int k = 0; k < 4; k++) send_item(32'sd3, k == 3);
      // reversed order
      for (int k = 0; k < 5; k++) send_item(value_type'(40 - 10 * k), k == 4);
      wait_drained();
   endtask

   task automatic test_capacity();
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      send_random_set(MAX_ELEMENTS);
      // closing item arrives with the store full
      send_random_set(MAX_ELEMENTS + 1);
      send_random_set(MAX_ELEMENTS + 3);
      // flag must be clear again
      send_random_set(2);
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> hold_go;
      for (int s = 0; s < 4; s++) send_random_set(10);
      wait_drained();
   endtask

   task automatic run_random_phase(input int n_items, input int send_p, input int stall_p);
      int start;
      int r;
      int len;
      send_idle_pct = send_p;
      rsp_stall_pct = stall_p;
      start = items_sent;
      while (items_sent - start < n_items) begin
         r = $urandom_range(99);
         if (r < 65)      len = $urandom_range(6, 1);
         else if (r < 88) len = $urandom_range(20, 7);
         else if (r < 97) len = $urandom_range(MAX_ELEMENTS, 21);
         else             len = $urandom_range(MAX_ELEMENTS + 6, MAX_ELEMENTS + 1);
         send_random_set(len);
      end
      wait_drained();
   endtask

   task automatic test_random();
      run_random_phase(25, 0, 0);
      run_random_phase(25, 77, 0);
      run_random_phase(25, 0, 77);
      run_random_phase(25, 18, 18);
   endtask

   always begin
      @(hold_go);
      receiver_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      receiver_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (receiver_hold) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall_pct == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_sorted.size() == 0) begin
            $error("unexpected result item: sorted_value %0d", rsp_data.sorted_value);
            errors++;
         end else begin
            wanted_rsp = pending_sorted.pop_front();
            results_seen++;
            if (rsp_data.sorted_value !== wanted_rsp.sorted_value) begin
               $error("sorted_value: expected %0d, actual %0d",
                      wanted_rsp.sorted_value, rsp_data.sorted_value);
               errors++;
            end
            if (rsp_data.final_res !== wanted_rsp.final_res) begin
               $error("final_res: expected %0b, actual %0b",
                      wanted_rsp.final_res, rsp_data.final_res);
               errors++;
            end
            if (rsp_data.overflow !== wanted_rsp.overflow) begin
               $error("overflow: expected %0b, actual %0b",
                      wanted_rsp.overflow, rsp_data.overflow);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
      end
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, pending_sorted.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity();
      test_backpressure();
      test_random();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d items in %0d sets sorted, %0d results checked, %0d sets overflowed",
               items_sent, sets_closed, results_seen, overflow_sets);
      $display("phases: edge values, capacity, receiver hold-off, random idle and stall");
      if (errors == 0 && pending_sorted.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
